@@ src/tpcc_pkg.sv @@
// Shared types, codes and constants of the two-player countdown clock.
`timescale 1ns / 1ps

package tpcc_pkg;

  // Field widths
  localparam int unsigned MIN_W      = 8;
  localparam int unsigned SEC_W      = 6;
  localparam int unsigned MS_W       = 20;
  localparam int unsigned INC_W      = 16;
  localparam int unsigned FALL_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Counter limits
  localparam logic [SEC_W-1:0] SEC_TOP   = SEC_W'(59);
  localparam logic [MS_W-1:0]  MS_RELOAD = MS_W'(999);
  localparam logic [MS_W-1:0]  MS_MAX    = {MS_W{1'b1}};

  // Configuration reset values
  localparam logic [MIN_W-1:0] START_MIN_RST = MIN_W'(5);
  localparam logic [SEC_W-1:0] START_SEC_RST = '0;
  localparam logic [INC_W-1:0] INC_RST       = '0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INC_MS    = 2'd2;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Flag-fall codes
  localparam logic [FALL_W-1:0] FALL_NONE  = 2'd0;
  localparam logic [FALL_W-1:0] FALL_WHITE = 2'd1;
  localparam logic [FALL_W-1:0] FALL_BLACK = 2'd2;

  typedef struct packed {
    logic [MIN_W-1:0] minutes;
    logic [SEC_W-1:0] seconds;
    logic [MS_W-1:0]  millis;
  } side_t;

  typedef struct packed {
    logic [MIN_W-1:0] start_minutes;
    logic [SEC_W-1:0] start_seconds;
    logic [INC_W-1:0] increment_ms;
  } cfg_t;

  typedef struct packed {
    logic operation;
    logic white_to_move;
  } in_item_t;

  typedef struct packed {
    logic [MIN_W-1:0]  white_minutes;
    logic [SEC_W-1:0]  white_seconds;
    logic [MS_W-1:0]   white_millis;
    logic [MIN_W-1:0]  black_minutes;
    logic [SEC_W-1:0]  black_seconds;
    logic [MS_W-1:0]   black_millis;
    logic              running;
    logic [FALL_W-1:0] flag_fallen;
  } out_item_t;

endpackage

@@ src/tpcc_chan_if.sv @@
// Valid/ready channel interface carrying one payload per transaction.
`timescale 1ns / 1ps

interface tpcc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/tpcc_cfg_regs.sv @@
// Configuration register bank of the countdown clock.
`timescale 1ns / 1ps

module tpcc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tpcc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tpcc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output tpcc_pkg::cfg_t                      cfg_o
);
  import tpcc_pkg::*;

  cfg_t cfg_q;

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_minutes <= START_MIN_RST;
      cfg_q.start_seconds <= START_SEC_RST;
      cfg_q.increment_ms  <= INC_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_MIN: cfg_q.start_minutes <= cfg_wdata_i[MIN_W-1:0];
        CFG_START_SEC: cfg_q.start_seconds <= cfg_wdata_i[SEC_W-1:0];
        CFG_INC_MS:    cfg_q.increment_ms  <= cfg_wdata_i[INC_W-1:0];
        default:       ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/tpcc_side.sv @@
// Per-player counter update: charge one millisecond and credit the increment.
`timescale 1ns / 1ps

module tpcc_side (
  input  tpcc_pkg::side_t                 cur_i,
  input  logic                            charge_i,
  input  logic                            credit_i,
  input  logic [tpcc_pkg::INC_W-1:0]      inc_i,
  output tpcc_pkg::side_t                 nxt_o,
  output logic                            fell_o
);
  import tpcc_pkg::*;

  side_t         charged;
  logic [MS_W:0] sum;

  // Spend the buffer, then borrow a second, then a minute
  always_comb begin
    charged = cur_i;
    fell_o  = 1'b0;
    if (charge_i) begin
      if (cur_i.millis != '0) begin
        charged.millis = cur_i.millis - MS_W'(1);
      end else if (cur_i.seconds != '0) begin
        charged.seconds = cur_i.seconds - SEC_W'(1);
        charged.millis  = MS_RELOAD;
      end else if (cur_i.minutes != '0) begin
        charged.minutes = cur_i.minutes - MIN_W'(1);
        charged.seconds = SEC_TOP;
        charged.millis  = MS_RELOAD;
      end else begin
        fell_o = 1'b1;
      end
    end
  end

  // Add the increment, saturating the buffer
  always_comb begin
    sum   = {1'b0, charged.millis} + (MS_W + 1)'(inc_i);
    nxt_o = charged;
    if (credit_i) begin
      nxt_o.millis = sum[MS_W] ? MS_MAX : sum[MS_W-1:0];
    end
  end

endmodule

@@ src/two_player_countdown_clock.sv @@
// Two-player countdown clock with per-move increment: input register, state, result register.
// The result register loads from the input register once the result register is free to take the item.
// Throughput: one item per cycle while the output is ready; the player update is a single combinational pass
// between the input register and the result/state registers.
// Output stalls hold the result register; the input register still takes a new item
// whenever the result register can drain in the same cycle.
// Reset: counters, flags and valid bits clear, white is to move, configuration is 5:00 +0.
`timescale 1ns / 1ps

module two_player_countdown_clock (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tpcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tpcc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  tpcc_chan_if.sink                       in_i,
  tpcc_chan_if.source                     out_o
);
  import tpcc_pkg::*;

  cfg_t              cfg;
  in_item_t          in_q;
  logic              in_vld_q;
  out_item_t         res_q;
  logic              res_vld_q;
  logic              adv;

  side_t             white_q, white_d, white_upd;
  side_t             black_q, black_d, black_upd;
  logic              last_white_q, last_white_d;
  logic              run_q, run_d;
  logic [FALL_W-1:0] fall_q, fall_d;
  logic              white_fell, black_fell;
  logic              tick_run, wtm;
  logic [SEC_W-1:0]  start_sec;

  tpcc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: move the held item on when the result register is free
  assign adv         = in_vld_q && (!res_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || adv;
  assign out_o.valid = res_vld_q;
  assign out_o.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        res_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Capture the input payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.payload;
    end
  end

  // Player updates: the side to move is charged, the side that just moved is credited
  assign wtm      = in_q.white_to_move;
  assign tick_run = (in_q.operation == OP_TICK) && run_q;

  tpcc_side u_white (
    .cur_i    (white_q),
    .charge_i (tick_run && wtm),
    .credit_i (tick_run && last_white_q && !wtm),
    .inc_i    (cfg.increment_ms),
    .nxt_o    (white_upd),
    .fell_o   (white_fell)
  );

  tpcc_side u_black (
    .cur_i    (black_q),
    .charge_i (tick_run && !wtm),
    .credit_i (tick_run && !last_white_q && wtm),
    .inc_i    (cfg.increment_ms),
    .nxt_o    (black_upd),
    .fell_o   (black_fell)
  );

  // Next state: load on start, update on a running tick, hold otherwise
  assign start_sec = (cfg.start_seconds > SEC_TOP) ? SEC_TOP : cfg.start_seconds;

  always_comb begin
    white_d      = white_q;
    black_d      = black_q;
    last_white_d = last_white_q;
    run_d        = run_q;
    fall_d       = fall_q;
    if (in_q.operation == OP_START) begin
      white_d      = '{minutes: cfg.start_minutes, seconds: start_sec, millis: '0};
      black_d      = '{minutes: cfg.start_minutes, seconds: start_sec, millis: '0};
      last_white_d = wtm;
      run_d        = 1'b1;
      fall_d       = FALL_NONE;
    end else if (run_q) begin
      white_d      = white_upd;
      black_d      = black_upd;
      last_white_d = wtm;
      if (white_fell) begin
        run_d  = 1'b0;
        fall_d = FALL_WHITE;
      end else if (black_fell) begin
        run_d  = 1'b0;
        fall_d = FALL_BLACK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_q      <= '0;
      black_q      <= '0;
      last_white_q <= 1'b1;
      run_q        <= 1'b0;
      fall_q       <= FALL_NONE;
    end else if (adv) begin
      white_q      <= white_d;
      black_q      <= black_d;
      last_white_q <= last_white_d;
      run_q        <= run_d;
      fall_q       <= fall_d;
    end
  end

  // Load the result register with the updated counters
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.white_minutes <= white_d.minutes;
      res_q.white_seconds <= white_d.seconds;
      res_q.white_millis  <= white_d.millis;
      res_q.black_minutes <= black_d.minutes;
      res_q.black_seconds <= black_d.seconds;
      res_q.black_millis  <= black_d.millis;
      res_q.running       <= run_d;
      res_q.flag_fallen   <= fall_d;
    end
  end

  // A fallen flag always means the clock has stopped
  a_fall_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fall_q != FALL_NONE) |-> !run_q)
    else $error("flag fallen while clock running");

  // A tick on a stopped clock leaves both players untouched
  a_stopped_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.operation == OP_TICK && !run_q) |=>
      ($stable(white_q) && $stable(black_q)))
    else $error("counters moved while stopped");

  // A held item is never dropped before it reaches the result register
  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> in_vld_q)
    else $error("input item lost");

  // Every moved item shows up as a valid result
  a_result_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> res_vld_q)
    else $error("result missing after transfer");

endmodule
